// File: rtl/pid_with_integral_clamp_macros.svh
// ----------------------------------------------------------------------------
// pid_with_integral_clamp assertion macros
// shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef PID_WITH_INTEGRAL_CLAMP_MACROS_SVH
`define PID_WITH_INTEGRAL_CLAMP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define PWIC_ASSERT(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("pid_with_integral_clamp assertion failed");

// antecedent implies consequent in the same cycle
`define PWIC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pid_with_integral_clamp assertion failed");

// antecedent implies consequent in the next cycle
`define PWIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pid_with_integral_clamp assertion failed");

`else

`define PWIC_ASSERT(label, clk, rstn, expr)
`define PWIC_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PWIC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/pwic_pkg.sv
// ----------------------------------------------------------------------------
// pwic_pkg
// types and constants shared by the pid controller modules
// ----------------------------------------------------------------------------
`default_nettype none

package pwic_pkg;

    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE = 3'd5;

    // register reset values
    localparam logic [30:0] STEP_TIME_RST = 31'd655;
    localparam logic [30:0] STEP_RATE_RST = 31'd6553600;

    // q16.16 constants
    localparam logic signed [31:0] S32_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN         = 32'sh8000_0000;
    localparam logic signed [31:0] INTEG_LIMIT     = 32'sd6553600;
    localparam logic signed [31:0] NEG_INTEG_LIMIT = -32'sd6553600;
    localparam logic signed [31:0] HALF_TURN       = 32'sd11796480;
    localparam logic signed [31:0] NEG_HALF_TURN   = -32'sd11796480;
    localparam logic signed [32:0] FULL_TURN       = 33'sd23592960;

    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic [30:0]        step_time;
        logic [30:0]        step_rate;
        logic               wrap_enable;
    } pwic_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_P,
        ST_MUL_II,
        ST_MUL_DD,
        ST_SUM
    } pwic_state_t;

    typedef enum logic [2:0] {
        MS_ERR_TIME,
        MS_DIFF_RATE,
        MS_GP_ERR,
        MS_GI_INT,
        MS_GD_DER
    } pwic_mul_sel_t;

    typedef struct packed {
        logic          load_in;
        logic          err_en;
        logic          mul_en;
        pwic_mul_sel_t mul_sel;
        logic          integ_en;
        logic          deriv_en;
        logic          acc_init;
        logic          acc_add;
        logic          out_load;
    } pwic_cmd_t;

    typedef struct packed {
        logic out_free;
    } pwic_status_t;

endpackage

`default_nettype wire

// File: rtl/pwic_regs.sv
// ----------------------------------------------------------------------------
// pwic_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module pwic_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pwic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    output pwic_pkg::pwic_cfg_t                  cfg
);
    import pwic_pkg::*;

    pwic_cfg_t cfg_reg;
    pwic_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_P:      cfg_next.gain_p      = $signed(cfg_data);
                REG_GAIN_I:      cfg_next.gain_i      = $signed(cfg_data);
                REG_GAIN_D:      cfg_next.gain_d      = $signed(cfg_data);
                REG_STEP_TIME:   cfg_next.step_time   = cfg_data[30:0];
                REG_STEP_RATE:   cfg_next.step_rate   = cfg_data[30:0];
                REG_WRAP_ENABLE: cfg_next.wrap_enable = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.step_time   <= STEP_TIME_RST;
            cfg_reg.step_rate   <= STEP_RATE_RST;
            cfg_reg.wrap_enable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pwic_ctrl.sv
// ----------------------------------------------------------------------------
// pwic_ctrl
// sequencer that steps the shared multiplier through one update
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_with_integral_clamp_macros.svh"

module pwic_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pwic_pkg::pwic_status_t status,
    output pwic_pkg::pwic_cmd_t        cmd
);
    import pwic_pkg::*;

    pwic_state_t state_reg;
    pwic_state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_ERR;
            ST_ERR:    state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_II;
            ST_MUL_II: state_next = ST_MUL_DD;
            ST_MUL_DD: state_next = ST_SUM;
            ST_SUM:    if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MS_ERR_TIME;
        unique case (state_reg)
            ST_IDLE: cmd.load_in = in_valid;
            ST_ERR:  cmd.err_en  = 1'b1;
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_ERR_TIME;
            end
            ST_MUL_D: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_DIFF_RATE;
                cmd.integ_en = 1'b1;
            end
            ST_MUL_P: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_GP_ERR;
                cmd.deriv_en = 1'b1;
            end
            ST_MUL_II: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_GI_INT;
                cmd.acc_init = 1'b1;
            end
            ST_MUL_DD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_GD_DER;
                cmd.acc_add = 1'b1;
            end
            ST_SUM:  cmd.out_load = status.out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PWIC_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, in_valid && in_ready, !in_ready)
    `PWIC_ASSERT_NEXT(a_sum_holds_on_stall, aclk, aresetn,
        (state_reg == ST_SUM) && !status.out_free, state_reg == ST_SUM)

endmodule

`default_nettype wire

// File: rtl/pwic_dp.sv
// ----------------------------------------------------------------------------
// pwic_dp
// pid datapath: error, shared multiplier, integral, derivative, output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_with_integral_clamp_macros.svh"

module pwic_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pwic_pkg::pwic_cfg_t   cfg,
    input  wire pwic_pkg::pwic_cmd_t   cmd,
    output pwic_pkg::pwic_status_t     status,
    input  wire logic signed [31:0]    setpoint,
    input  wire logic signed [31:0]    measured,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         drive
);
    import pwic_pkg::*;

    logic signed [31:0] sp_reg, ms_reg;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] last_err_reg;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [63:0] prod_reg;
    logic signed [49:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_data_reg, out_data_next;

    logic signed [32:0] diff;
    logic signed [31:0] err_sat;
    logic signed [32:0] err_fold;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] product;
    logic signed [47:0] prod_q;
    logic signed [48:0] integ_sum;
    logic signed [49:0] sum_fin;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign drive           = out_data_reg;

    // error with saturation and optional single fold
    always_comb begin
        diff    = {sp_reg[31], sp_reg} - {ms_reg[31], ms_reg};
        err_sat = (diff[32] != diff[31]) ? (diff[32] ? S32_MIN : S32_MAX) : diff[31:0];
        err_fold = {err_sat[31], err_sat};
        if (cfg.wrap_enable) begin
            if (err_sat > HALF_TURN) begin
                err_fold = {err_sat[31], err_sat} - FULL_TURN;
            end else if (err_sat < NEG_HALF_TURN) begin
                err_fold = {err_sat[31], err_sat} + FULL_TURN;
            end
        end
        err_next = err_fold[31:0];
    end

    // shared multiplier operand select
    always_comb begin
        unique case (cmd.mul_sel)
            MS_ERR_TIME: begin
                mul_a = 33'(err_reg);
                mul_b = $signed({2'b00, cfg.step_time});
            end
            MS_DIFF_RATE: begin
                mul_a = 33'(err_reg) - 33'(last_err_reg);
                mul_b = $signed({2'b00, cfg.step_rate});
            end
            MS_GP_ERR: begin
                mul_a = 33'(cfg.gain_p);
                mul_b = 33'(err_reg);
            end
            MS_GI_INT: begin
                mul_a = 33'(cfg.gain_i);
                mul_b = 33'(integ_reg);
            end
            MS_GD_DER: begin
                mul_a = 33'(cfg.gain_d);
                mul_b = 33'(deriv_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = mul_a * mul_b;
    end

    // floor of the registered product by 2^16
    assign prod_q = $signed(prod_reg[63:16]);

    always_comb begin
        integ_sum = 49'(integ_reg) + 49'(prod_q);
        if (integ_sum > 49'(INTEG_LIMIT)) begin
            integ_next = INTEG_LIMIT;
        end else if (integ_sum < 49'(NEG_INTEG_LIMIT)) begin
            integ_next = NEG_INTEG_LIMIT;
        end else begin
            integ_next = integ_sum[31:0];
        end

        if (prod_q > 48'(S32_MAX)) begin
            deriv_next = S32_MAX;
        end else if (prod_q < 48'(S32_MIN)) begin
            deriv_next = S32_MIN;
        end else begin
            deriv_next = prod_q[31:0];
        end

        acc_next = acc_reg;
        if (cmd.acc_init) begin
            acc_next = 50'(prod_q);
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + 50'(prod_q);
        end

        sum_fin = acc_reg + 50'(prod_q);
        if (sum_fin > 50'(S32_MAX)) begin
            out_data_next = S32_MAX;
        end else if (sum_fin < 50'(S32_MIN)) begin
            out_data_next = S32_MIN;
        end else begin
            out_data_next = sum_fin[31:0];
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // controller state: integral, previous error, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.integ_en) integ_reg <= integ_next;
            if (cmd.deriv_en) last_err_reg <= err_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sp_reg <= setpoint;
            ms_reg <= measured;
        end
        if (cmd.err_en)   err_reg   <= err_next;
        if (cmd.mul_en)   prod_reg  <= $signed(product[63:0]);
        if (cmd.deriv_en) deriv_reg <= deriv_next;
        acc_reg <= acc_next;
        if (cmd.out_load) out_data_reg <= out_data_next;
    end

    `PWIC_ASSERT(a_integ_bound, aclk, aresetn,
        (integ_reg <= INTEG_LIMIT) && (integ_reg >= NEG_INTEG_LIMIT))
    `PWIC_ASSERT_IMPL(a_load_only_when_free, aclk, aresetn, cmd.out_load,
        !out_valid_reg || out_ready)

endmodule

`default_nettype wire

// File: rtl/pid_with_integral_clamp.sv
// a result is presented once its input transaction has passed the sequencer steps:
//   accept, error, five passes through the one shared 33x33 multiplier and the
//   final sum, which stalls until the output register is free, one item at a time
// a finished result waits in the output register while the next item is taken
// reset: synchronous active-low aresetn returns the config and state registers to their reset
//   values and clears integral, previous error and output valid at once
// ----------------------------------------------------------------------------
// pid_with_integral_clamp
// single-axis q16.16 pid controller with clamped integral and optional yaw wrap
// ----------------------------------------------------------------------------
`default_nettype none

module pid_with_integral_clamp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [63:0]                     s_tdata,   // [31:0] setpoint, [63:32] measured
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,   // [31:0] drive
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pwic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import pwic_pkg::*;

    pwic_cfg_t          cfg;
    pwic_cmd_t          cmd;
    pwic_status_t       status;
    logic signed [31:0] drive;

    // register file: gains, step time, step rate, wrap enable
    pwic_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: takes one transaction, then steps the datapath
    pwic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: error, shared multiplier, integral clamp, derivative, output reg
    pwic_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .setpoint  ($signed(s_tdata[31:0])),
        .measured  ($signed(s_tdata[63:32])),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (drive)
    );

    assign m_tdata = drive;

endmodule

`default_nettype wire
